>>> src/fpm_pkg.sv
// shared constants and types for the single-precision multiplier
package fpm_pkg;
	localparam int unsigned WordW = 32;
	localparam int unsigned ExpW = 8;
	localparam int unsigned FracW = 23;
	localparam int unsigned SigW = FracW + 1;
	localparam int unsigned ProdW = 2 * SigW;
	localparam int unsigned ExpSumW = ExpW + 2;
	localparam logic [ExpW-1:0] ExpMax = '1;
	localparam logic [ExpSumW-1:0] Bias = ExpSumW'(127);
	localparam logic [WordW-1:0] QnanBits = 32'h7fc0_0000;
	localparam logic [WordW-1:0] InfBits = 32'h7f80_0000;

	// special-case code decided in the first stage
	localparam logic [1:0] KindNorm = 2'd0;
	localparam logic [1:0] KindNan = 2'd1;
	localparam logic [1:0] KindInf = 2'd2;
	localparam logic [1:0] KindZero = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic sign;
		logic signed [ExpSumW-1:0] exp;
	} ctl_t;
endpackage

>>> src/fpm_if.sv
// valid/ready channel carrying a fixed-width payload
interface fpm_if #(parameter int unsigned W = 32) (input logic clk);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/fp32_multiplier.sv
// top level of the pipelined binary32 multiplier
// Three-stage pipeline: decode, 24x24 significand multiply, then round into the output
// register. A new request is taken every cycle while the output is not stalled; each
// result passes the s1, s2 and s3 registers in turn. Stalls hold all stages; nothing is
// dropped. Subnormals count as zero, results are flushed to zero on underflow, NaN is
// always 0x7FC00000.
module fp32_multiplier (
	input  logic clk,
	input  logic arst_n,
	fpm_if.sink in_a,
	fpm_if.sink in_b,
	fpm_if.source out_p
);
	fpm_pkg::ctl_t ctl, ctl_s1, ctl_s2;
	logic [fpm_pkg::SigW-1:0] sig_a, sig_b, sig_a_s1, sig_b_s1;
	logic [fpm_pkg::ProdW-1:0] prod_s2;
	logic [fpm_pkg::WordW-1:0] product, product_s3;
	logic v_s1, v_s2, v_s3, adv;
	logic in_valid;

	assign in_valid = in_a.valid && in_b.valid;
	assign adv = !v_s3 || out_p.ready;
	assign in_a.ready = adv && in_b.valid;
	assign in_b.ready = adv && in_a.valid;
	assign out_p.valid = v_s3;
	assign out_p.data = product_s3;

	fpm_unpack u_unpack (
		.operand_a(in_a.data), .operand_b(in_b.data),
		.ctl(ctl), .sig_a(sig_a), .sig_b(sig_b)
	);

	fpm_round u_round (.ctl(ctl_s2), .prod(prod_s2), .product(product));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= ctl;
			sig_a_s1 <= sig_a;
			sig_b_s1 <= sig_b;
			ctl_s2 <= ctl_s1;
			prod_s2 <= fpm_pkg::ProdW'(sig_a_s1) * fpm_pkg::ProdW'(sig_b_s1);
			product_s3 <= product;
		end
	end
endmodule

>>> src/fpm_unpack.sv
// stage 1: operand decode, special cases and exponent sum
module fpm_unpack (
	input  logic [fpm_pkg::WordW-1:0] operand_a,
	input  logic [fpm_pkg::WordW-1:0] operand_b,
	output fpm_pkg::ctl_t ctl,
	output logic [fpm_pkg::SigW-1:0] sig_a,
	output logic [fpm_pkg::SigW-1:0] sig_b
);
	logic [fpm_pkg::ExpW-1:0] ea, eb;
	logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;

	always_comb begin
		ea = operand_a[30:23];
		eb = operand_b[30:23];
		nan_a = (ea == fpm_pkg::ExpMax) && (operand_a[22:0] != '0);
		nan_b = (eb == fpm_pkg::ExpMax) && (operand_b[22:0] != '0);
		inf_a = (ea == fpm_pkg::ExpMax) && (operand_a[22:0] == '0);
		inf_b = (eb == fpm_pkg::ExpMax) && (operand_b[22:0] == '0);
		zero_a = (ea == '0);
		zero_b = (eb == '0);
		ctl.sign = operand_a[31] ^ operand_b[31];
		ctl.exp = $signed({2'b00, ea} + {2'b00, eb} - fpm_pkg::Bias);
		if (nan_a || nan_b) begin
			ctl.kind = fpm_pkg::KindNan;
		end else if (inf_a || inf_b) begin
			ctl.kind = (zero_a || zero_b) ? fpm_pkg::KindNan : fpm_pkg::KindInf;
		end else if (zero_a || zero_b) begin
			ctl.kind = fpm_pkg::KindZero;
		end else begin
			ctl.kind = fpm_pkg::KindNorm;
		end
		sig_a = {1'b1, operand_a[22:0]};
		sig_b = {1'b1, operand_b[22:0]};
	end
endmodule

>>> src/fpm_round.sv
// stage 3: normalise, round to nearest even, range check and pack
module fpm_round (
	input  fpm_pkg::ctl_t ctl,
	input  logic [fpm_pkg::ProdW-1:0] prod,
	output logic [fpm_pkg::WordW-1:0] product
);
	logic [fpm_pkg::SigW:0] mant;
	logic guard, sticky, up;
	logic signed [fpm_pkg::ExpSumW-1:0] e;

	always_comb begin
		if (prod[47]) begin
			mant = {1'b0, prod[47:24]};
			guard = prod[23];
			sticky = prod[22:0] != '0;
			e = ctl.exp + fpm_pkg::ExpSumW'(1);
		end else begin
			mant = {1'b0, prod[46:23]};
			guard = prod[22];
			sticky = prod[21:0] != '0;
			e = ctl.exp;
		end
		up = guard && (sticky || mant[0]);
		mant = mant + (fpm_pkg::SigW+1)'(up);
		if (mant[24]) begin
			mant = mant >> 1;
			e = e + fpm_pkg::ExpSumW'(1);
		end
		case (ctl.kind)
			fpm_pkg::KindNan: product = fpm_pkg::QnanBits;
			fpm_pkg::KindInf: product = {ctl.sign, 31'b0} | fpm_pkg::InfBits;
			fpm_pkg::KindZero: product = {ctl.sign, 31'b0};
			default: begin
				if (e >= $signed(fpm_pkg::ExpSumW'(255))) begin
					product = {ctl.sign, 31'b0} | fpm_pkg::InfBits;
				end else if (e <= 0) begin
					product = {ctl.sign, 31'b0};
				end else begin
					product = {ctl.sign, e[7:0], mant[22:0]};
				end
			end
		endcase
	end
endmodule

>>> src/fpm_checker.sv
// port-level checks for the multiplier, bound to the top level
module fpm_port_checker (
	input logic clk,
	input logic arst_n,
	input logic a_ready,
	input logic b_valid,
	input logic p_valid,
	input logic p_ready,
	input logic [31:0] p_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		p_valid && !p_ready |=> p_valid && $stable(p_data))
		else $error("result changed while stalled");
	a_nan_canon: assert property (@(posedge clk) disable iff (!arst_n)
		p_valid && p_data[30:23] == 8'hff && p_data[22:0] != 0 |-> p_data == 32'h7fc00000)
		else $error("non-canonical nan");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!p_valid && b_valid |-> a_ready)
		else $error("request refused with empty output");
	a_no_sub: assert property (@(posedge clk) disable iff (!arst_n)
		p_valid && p_data[30:23] == 8'h00 |-> p_data[22:0] == 0)
		else $error("subnormal result");
endmodule

bind fp32_multiplier fpm_port_checker u_fpm_checker (
	.clk(clk), .arst_n(arst_n),
	.a_ready(in_a.ready), .b_valid(in_b.valid),
	.p_valid(out_p.valid), .p_ready(out_p.ready), .p_data(out_p.data)
);

>>> dv/fpm_checker.sv
// product checker: watches the operand and product channels and compares each product
`timescale 1ns / 1ps
module fpm_checker (
	input  logic clk,
	input  logic arst_n,
	fpm_if a_ch,
	fpm_if b_ch,
	fpm_if p_ch,
	output int unsigned fail_count,
	output int unsigned pending
);
	logic [fpm_pkg::WordW-1:0] a_words[$];
	logic [fpm_pkg::WordW-1:0] b_words[$];
	logic [fpm_pkg::WordW-1:0] products_due[$];
	logic [fpm_pkg::WordW-1:0] a_pop, b_pop, due;

	function automatic logic [fpm_pkg::WordW-1:0] mul_predict(logic [fpm_pkg::WordW-1:0] a,
		logic [fpm_pkg::WordW-1:0] b);
		logic sgn;
		logic [fpm_pkg::ExpW-1:0] ea, eb;
		logic [fpm_pkg::FracW-1:0] fa, fb;
		logic [fpm_pkg::ProdW-1:0] prod, rem, half;
		logic [fpm_pkg::SigW:0] mant;
		int e;
		int sh;
		sgn = a[31] ^ b[31];
		ea = a[30:23];
		eb = b[30:23];
		fa = a[22:0];
		fb = b[22:0];
		if ((ea == fpm_pkg::ExpMax && fa != 0) || (eb == fpm_pkg::ExpMax && fb != 0))
			return fpm_pkg::QnanBits;
		if (ea == fpm_pkg::ExpMax || eb == fpm_pkg::ExpMax) begin
			if (ea == 0 || eb == 0)
				return fpm_pkg::QnanBits;
			return {sgn, fpm_pkg::InfBits[30:0]};
		end
		if (ea == 0 || eb == 0)
			return {sgn, 31'd0};
		prod = fpm_pkg::ProdW'({1'b1, fa}) * fpm_pkg::ProdW'({1'b1, fb});
		e = int'(ea) + int'(eb) - 127;
		if (prod[fpm_pkg::ProdW-1]) begin
			sh = 24;
			e++;
		end else begin
			sh = 23;
		end
		mant = (fpm_pkg::SigW+1)'(prod >> sh);
		rem = prod & ((fpm_pkg::ProdW'(1) << sh) - fpm_pkg::ProdW'(1));
		half = fpm_pkg::ProdW'(1) << (sh - 1);
		if (rem > half || (rem == half && mant[0]))
			mant = mant + (fpm_pkg::SigW+1)'(1);
		if (mant[fpm_pkg::SigW]) begin
			mant = mant >> 1;
			e++;
		end
		if (e >= 255)
			return {sgn, fpm_pkg::InfBits[30:0]};
		if (e <= 0)
			return {sgn, 31'd0};
		return {sgn, 8'(e), mant[fpm_pkg::FracW-1:0]};
	endfunction

	task automatic report_mismatch(string what, logic [fpm_pkg::WordW-1:0] got,
		logic [fpm_pkg::WordW-1:0] want);
		$display("[%0t] %s: got %08h want %08h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			fail_count = 0;
		end else begin
			if (a_ch.valid && a_ch.ready)
				a_words.push_back(a_ch.data);
			if (b_ch.valid && b_ch.ready)
				b_words.push_back(b_ch.data);
			while (a_words.size() > 0 && b_words.size() > 0) begin
				a_pop = a_words.pop_front();
				b_pop = b_words.pop_front();
				products_due.push_back(mul_predict(a_pop, b_pop));
			end
			if (p_ch.valid && p_ch.ready) begin
				if (products_due.size() == 0) begin
					report_mismatch("unexpected product", p_ch.data, '0);
				end else begin
					due = products_due.pop_front();
					if (p_ch.data !== due)
						report_mismatch("product", p_ch.data, due);
				end
			end
		end
	end

	assign pending = products_due.size() + ((a_words.size() > b_words.size()) ?
		a_words.size() : b_words.size());
endmodule

>>> dv/tb_top.sv
// testbench top: operand stimulus, result back-pressure and final verdict
`timescale 1ns / 1ps
module tb_top;
	localparam int unsigned CycleLimit = 400000;

	logic clk;
	logic arst_n;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned cycles;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	logic hold_off;

	fpm_if #(fpm_pkg::WordW) a_ch (clk);
	fpm_if #(fpm_pkg::WordW) b_ch (clk);
	fpm_if #(fpm_pkg::WordW) p_ch (clk);

	fp32_multiplier dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_a(a_ch.sink),
		.in_b(b_ch.sink),
		.out_p(p_ch.source)
	);

	fpm_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.a_ch(a_ch),
		.b_ch(b_ch),
		.p_ch(p_ch),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_ch.ready <= 1'b0;
		end else begin
			p_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic logic [fpm_pkg::WordW-1:0] rand_operand();
		logic [fpm_pkg::ExpW-1:0] ex;
		logic [fpm_pkg::FracW-1:0] fr;
		fr = 23'($urandom);
		ex = 8'($urandom);
		case ($urandom_range(9))
			0: ex = 8'd0;
			1: ex = fpm_pkg::ExpMax;
			2: ex = 8'($urandom_range(1, 20));
			3: ex = 8'($urandom_range(235, 254));
			4: fr = ($urandom_range(1)) ? '0 : 23'h7fffff;
			5, 6: ex = 8'($urandom_range(100, 160));
			default: ex = 8'($urandom);
		endcase
		if ($urandom_range(9) == 4)
			return $urandom;
		if ($urandom_range(9) == 3)
			fr = fr & ~23'(($urandom_range(1) << 22));
		return {1'($urandom), ex, fr};
	endfunction

	task automatic send_pair(logic [fpm_pkg::WordW-1:0] a, logic [fpm_pkg::WordW-1:0] b);
		logic done_a, done_b, ta, tb;
		int unsigned gap;
		if ($urandom_range(99) < send_idle_pct) begin
			a_ch.valid <= 1'b0;
			b_ch.valid <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
		end
		a_ch.valid <= 1'b1;
		a_ch.data <= a;
		b_ch.valid <= 1'b1;
		b_ch.data <= b;
		done_a = 1'b0;
		done_b = 1'b0;
		while (!(done_a && done_b)) begin
			@(negedge clk);
			ta = a_ch.valid && a_ch.ready;
			tb = b_ch.valid && b_ch.ready;
			@(posedge clk);
			done_a = done_a || ta;
			done_b = done_b || tb;
			if (ta && !done_b)
				a_ch.valid <= 1'b0;
			if (tb && !done_a)
				b_ch.valid <= 1'b0;
		end
	endtask

	task automatic random_phase(int unsigned n);
		repeat (n) send_pair(rand_operand(), rand_operand());
	endtask

	initial begin
		logic [fpm_pkg::WordW-1:0] dir_a[$];
		logic [fpm_pkg::WordW-1:0] dir_b[$];
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		a_ch.valid <= 1'b0;
		a_ch.data <= '0;
		b_ch.valid <= 1'b0;
		b_ch.data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zeros, infinities, nans, subnormals, overflow, underflow, rounding near ties
		dir_a = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000, 32'h7fc0_0000,
			32'hffff_ffff, 32'h0000_0001, 32'h807f_ffff, 32'h7f7f_ffff, 32'h0080_0000,
			32'h3f80_0000, 32'hbfc0_0000, 32'h3f80_0001, 32'h3fff_ffff, 32'h7f7f_ffff,
			32'h0080_0000, 32'h1f80_0000, 32'h3f00_0000, 32'h7f80_0001, 32'h4b80_0001};
		dir_b = '{32'h7f80_0000, 32'h3f80_0000, 32'h8000_0000, 32'h4000_0000, 32'h3f80_0000,
			32'h0000_0000, 32'h3f80_0000, 32'h4000_0000, 32'h4000_0000, 32'h3f00_0000,
			32'h3f80_0000, 32'h3fc0_0000, 32'h3fbf_ffff, 32'h3fff_ffff, 32'hff7f_ffff,
			32'h0080_0000, 32'h1f80_0000, 32'h0100_0000, 32'h3f80_0000, 32'h3f80_0001};
		foreach (dir_a[i])
			send_pair(dir_a[i], dir_b[i]);

		send_idle_pct = 38;
		recv_idle_pct = 82;
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
		join_none
		random_phase(660);
		send_idle_pct = 82;
		recv_idle_pct = 38;
		random_phase(660);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(660);
		a_ch.valid <= 1'b0;
		b_ch.valid <= 1'b0;

		while (pending != 0 || hold_off)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

>>> sim.f
src/fpm_pkg.sv
src/fpm_if.sv
src/fpm_unpack.sv
src/fpm_round.sv
src/fp32_multiplier.sv
src/fpm_checker.sv
dv/fpm_checker.sv
dv/tb_top.sv
